/* sv/sit_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the string intern table.
`default_nettype none
package sit_pkg;
   localparam int ENTRIES   = 64;
   localparam int MAX_CHARS = 8;
   localparam int TEXT_W    = 64;
   localparam int SLOT_W    = 6;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam logic [7:0] BYTE_MASK = 8'hff;

   typedef enum logic [1:0] {
      STATUS_EXISTING = 2'd0,
      STATUS_ADDED    = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic fin_hit;
      logic fin_add;
      logic fin_full;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic miss_done;
      logic full;
      logic out_free;
   } sts_type;
endpackage
`default_nettype wire

/* sv/string_intern_table.sv */
// Top level of the string intern table: controller, datapath and checks.
// A request carries one string of up to eight bytes on req_text, first character
// in the low byte; bytes from the first zero byte on are ignored. The table looks
// the string up among the stored entries from entry 0 and answers with one result:
// the index of the equal entry (status existing), or the next free slot where the
// string is now stored (status added), or index zero with status full.
// The search reads one stored entry per cycle from the string memory and compares
// at most 64 stored entries per request; the memory read port sets that rate.
// One request is in work at a time, and req_ready is high while the block is idle.
// The result sits in an output register; the next request is taken while it
// waits, and its search stalls at the end until the receiver takes the older one.
// Reset empties the table (the entry count goes to zero) and drops any result.
`default_nettype none
module string_intern_table
   import sit_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [TEXT_W-1:0] req_text,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [SLOT_W-1:0]      rsp_slot_index,
   output logic [1:0]             rsp_status
);
   cmd_type cmd;
   sts_type sts;

   sit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sit_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_text       (req_text),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_slot_index (rsp_slot_index),
      .rsp_status     (rsp_status)
   );

   a_one_finish: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.fin_hit, cmd.fin_add, cmd.fin_full}))
      else $error("more than one finish command at once");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.fin_hit || cmd.fin_add || cmd.fin_full) |-> sts.out_free)
      else $error("result written over an unaccepted result");

   a_no_add_full: assert property (@(posedge clock) disable iff (reset)
      cmd.fin_add |-> !sts.full)
      else $error("insert into a full table");

   a_finish_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.fin_hit || cmd.fin_add || cmd.fin_full) |=> rsp_valid)
      else $error("finished search without a result");
endmodule
`default_nettype wire

/* sv/sit_dp.sv */
// Datapath of the string intern table: string store, search pipeline, count and result register.
`default_nettype none
module sit_dp
   import sit_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output sts_type                sts,
   input  wire logic [TEXT_W-1:0] req_text,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [SLOT_W-1:0]      rsp_slot_index,
   output logic [1:0]             rsp_status
);
   logic [TEXT_W-1:0] mem [ENTRIES];
   logic [TEXT_W-1:0] word_ff, word_in, rd_data_ff;
   logic [CNT_W-1:0]  count_ff, rd_idx_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic              cmp_vld_ff, rd_en, match;
   logic              rsp_valid_ff;
   logic [SLOT_W-1:0] slot_ff;
   status_type        status_ff;

   always_comb begin
      logic run;
      run = 1'b1;
      word_in = '0;
      for (int pos = 0; pos < 8; pos++) begin
         if (pos >= MAX_CHARS || (req_text[8*pos +: 8] & BYTE_MASK) == 8'd0) begin
            run = 1'b0;
         end
         if (run) begin
            word_in[8*pos +: 8] = req_text[8*pos +: 8];
         end
      end
   end

   assign rd_en = cmd.scan && (rd_idx_ff < count_ff);
   assign match = cmp_vld_ff && (rd_data_ff == word_ff);

   assign sts.hit       = match;
   assign sts.miss_done = !match && ((count_ff == '0) ||
                          (cmp_vld_ff && ({1'b0, cmp_idx_ff} == count_ff - CNT_W'(1))));
   assign sts.full      = (count_ff == CNT_W'(ENTRIES));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx_ff[IDX_W-1:0]];
      end
      if (cmd.fin_add) begin
         mem[count_ff[IDX_W-1:0]] <= word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            word_ff    <= word_in;
            rd_idx_ff  <= '0;
            cmp_vld_ff <= 1'b0;
         end else if (cmd.scan) begin
            cmp_vld_ff <= rd_en;
            cmp_idx_ff <= rd_idx_ff[IDX_W-1:0];
            if (rd_en) begin
               rd_idx_ff <= rd_idx_ff + CNT_W'(1);
            end
         end
         if (cmd.fin_hit) begin
            slot_ff   <= SLOT_W'(cmp_idx_ff);
            status_ff <= STATUS_EXISTING;
         end else if (cmd.fin_add) begin
            slot_ff   <= SLOT_W'(count_ff);
            status_ff <= STATUS_ADDED;
            count_ff  <= count_ff + CNT_W'(1);
         end else if (cmd.fin_full) begin
            slot_ff   <= '0;
            status_ff <= STATUS_FULL;
         end
         if (cmd.fin_hit || cmd.fin_add || cmd.fin_full) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = slot_ff;
   assign rsp_status     = status_ff;
endmodule
`default_nettype wire

/* sv/sit_ctrl.sv */
// Controller state machine of the string intern table.
`default_nettype none
module sit_ctrl
   import sit_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   typedef enum logic {IDLE, SCAN} state_type;
   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               if ((sts.hit || sts.miss_done) && sts.out_free) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == IDLE);

   always_comb begin
      logic done;
      done = (state_ff == SCAN) && sts.out_free;
      cmd.load     = (state_ff == IDLE) && req_valid;
      cmd.scan     = (state_ff == SCAN) && !sts.hit && !sts.miss_done;
      cmd.fin_hit  = done && sts.hit;
      cmd.fin_add  = done && sts.miss_done && !sts.full;
      cmd.fin_full = done && sts.miss_done && sts.full;
   end
endmodule
`default_nettype wire
